// ===== rtl/relay_pid_autotuner_top_defines.svh =====
// ----------------------------------------------------------------------------
// Relay PID autotuner assertion macros
// Shared concurrent assertion wrappers for the autotuner RTL.
// ----------------------------------------------------------------------------
`ifndef RELAY_PID_AUTOTUNER_TOP_DEFINES_SVH
`define RELAY_PID_AUTOTUNER_TOP_DEFINES_SVH
`ifndef SYNTH
// checked outside of reset
`define RPA_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("autotuner assertion failed");
// checked at every edge, reset included
`define RPA_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("autotuner assertion failed");
`else
`define RPA_ASSERT(lbl, prop)
`define RPA_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== rtl/rpa_pkg.sv =====
// ----------------------------------------------------------------------------
// Relay PID autotuner package
// Types, request codes and fixed-point constants shared by the autotuner.
// ----------------------------------------------------------------------------
package rpa_pkg;

	// field widths
	localparam int unsigned TEMP_W   = 15;
	localparam int unsigned TIME_W   = 32;
	localparam int unsigned AMP_W    = 10;
	localparam int unsigned PCT_W    = 7;
	localparam int unsigned KP_W     = 17;
	localparam int unsigned KI_W     = 14;
	localparam int unsigned KD_W     = 17;
	localparam int unsigned REQ_W    = 2;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DAT_W = 15;

	localparam int unsigned QUEUE_DEPTH = 2;

	// request codes
	localparam logic [REQ_W-1:0] REQ_SAMPLE = 2'd0;
	localparam logic [REQ_W-1:0] REQ_START  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_CANCEL = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SETPOINT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RELAY_D  = 1'd1;

	localparam logic [TEMP_W-1:0] SETPOINT_RST = 15'd3750;
	localparam logic [AMP_W-1:0]  RELAY_D_RST  = 10'd50;

	// timing limits in ms
	localparam logic [TIME_W-1:0] SAFETY_MS  = 32'd5000;
	localparam logic [TIME_W-1:0] TIMEOUT_MS = 32'd1800000;

	// elapsed/18000 as (x * PCT_RECIP) >> PCT_SHIFT, exact for x below 2^21
	localparam int unsigned       PCT_IN_W  = 21;
	localparam int unsigned       PCT_SHIFT = 35;
	localparam logic [20:0]       PCT_RECIP = 21'd1908875;
	localparam logic [PCT_W-1:0]  PCT_CAP   = 7'd95;
	localparam logic [PCT_W-1:0]  PCT_DONE  = 7'd100;

	// gain arithmetic constants (pi = 314159/100000)
	localparam logic [63:0] K_PI     = 64'd314159;
	localparam logic [63:0] K_KP_NUM = 64'd48000000000;
	localparam logic [63:0] K_KI_NUM = 64'd96000000000000;
	localparam logic [63:0] K_KD_NUM = 64'd6000000;

	// gain limits
	localparam logic [63:0] KP_MIN = 64'd100;
	localparam logic [63:0] KP_MAX = 64'd100000;
	localparam logic [63:0] KI_MIN = 64'd10;
	localparam logic [63:0] KI_MAX = 64'd10000;
	localparam logic [63:0] KD_MIN = 64'd100;
	localparam logic [63:0] KD_MAX = 64'd100000;

	typedef enum logic [2:0] {
		PH_CANCELED = 3'd0,
		PH_INIT     = 3'd1,
		PH_PEAK1    = 3'd2,
		PH_PEAK2    = 3'd3,
		PH_FINISHED = 3'd4
	} phase_t;

	// one queued request
	typedef struct packed {
		logic [REQ_W-1:0]         req;
		logic signed [TEMP_W-1:0] temp;
		logic [TIME_W-1:0]        now;
	} item_t;

	typedef enum logic {
		ALU_MUL = 1'b0,
		ALU_DIV = 1'b1
	} alu_op_t;

	// request to the shared serial unit
	typedef struct packed {
		logic        start;
		alu_op_t     op;
		logic [63:0] opa;   // multiplicand or dividend
		logic [63:0] opb;   // multiplier (low 32 bits) or divisor
	} alu_req_t;

	// response of the shared serial unit
	typedef struct packed {
		logic        busy;
		logic        done;
		logic        ovf;   // product reached 2^64
		logic [63:0] res;
	} alu_rsp_t;

	typedef enum logic [3:0] {
		BS_IDLE  = 4'd0,
		BS_DEN   = 4'd1,
		BS_NKP   = 4'd2,
		BS_KP    = 4'd3,
		BS_NKI   = 4'd4,
		BS_DT    = 4'd5,
		BS_KI    = 4'd6,
		BS_N1    = 4'd7,
		BS_NT    = 4'd8,
		BS_KD    = 4'd9,
		BS_WRITE = 4'd10
	} back_state_t;

endpackage

// ===== rtl/relay_pid_autotuner_top.sv =====
// ----------------------------------------------------------------------------
// Relay PID autotuner
// Relay-feedback autotuner with Ziegler-Nichols gain computation.
// ----------------------------------------------------------------------------
// Usage:
//   Requests (start, cancel, timestamped sample) arrive on the in channel;
//   a transfer happens when in_valid is high and in_stall is low. Every
//   request yields exactly one result on the out channel (out_valid/out_stall)
//   carrying heater drive, phase, progress and the current gains.
//   Setpoint and relay amplitude are written on the cfg channel
//   (cfg_valid/cfg_ready, always ready) while no request is in flight.
// Throughput:
//   A request passes a two-entry queue and is executed into the result
//   register; one request per cycle is sustained while results are not
//   stalled and no gain sequence runs. The sample that finds the second peak
//   may run the gain sequence on the shared serial unit (at most six 32-step
//   multiplies and three 64-step divides) before its result is shown.
// Reset: arst_n clears the queue, the result valid flag, tuning phase
//   (canceled), heater, peak detector and gains (zero).
// Stall: a held result blocks the back end; the queue then fills and
//   in_stall rises. Nothing is lost.
// ----------------------------------------------------------------------------
module relay_pid_autotuner_top #(
	parameter int unsigned QDEPTH = rpa_pkg::QUEUE_DEPTH
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [rpa_pkg::REQ_W-1:0]            req_type,
	input  logic signed [rpa_pkg::TEMP_W-1:0]    temp_centi,
	input  logic [rpa_pkg::TIME_W-1:0]           now_ms,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 heater_on,
	output logic [2:0]                           phase,
	output logic [rpa_pkg::PCT_W-1:0]            progress_pct,
	output logic [rpa_pkg::KP_W-1:0]             kp_milli,
	output logic [rpa_pkg::KI_W-1:0]             ki_milli,
	output logic [rpa_pkg::KD_W-1:0]             kd_milli,
	output logic                                 done_res,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [rpa_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [rpa_pkg::CFG_DAT_W-1:0]        cfg_data
);

	logic signed [rpa_pkg::TEMP_W-1:0] setpoint_q;
	logic [rpa_pkg::AMP_W-1:0]         relay_d_q;
	logic                              q_valid;
	logic                              q_pop;
	rpa_pkg::item_t                    q_item;
	rpa_pkg::alu_req_t                 alu_req;
	rpa_pkg::alu_rsp_t                 alu_rsp;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q <= rpa_pkg::SETPOINT_RST;
			relay_d_q  <= rpa_pkg::RELAY_D_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				rpa_pkg::CFG_SETPOINT: setpoint_q <= cfg_data;
				rpa_pkg::CFG_RELAY_D:  relay_d_q  <= cfg_data[rpa_pkg::AMP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	rpa_front #(
		.DEPTH(QDEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.temp_centi (temp_centi),
		.now_ms     (now_ms),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop)
	);

	rpa_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.rsp    (alu_rsp)
	);

	rpa_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.q_pop        (q_pop),
		.setpoint     (setpoint_q),
		.relay_d      (relay_d_q),
		.alu_req      (alu_req),
		.alu_rsp      (alu_rsp),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.heater_on    (heater_on),
		.phase        (phase),
		.progress_pct (progress_pct),
		.kp_milli     (kp_milli),
		.ki_milli     (ki_milli),
		.kd_milli     (kd_milli),
		.done_res     (done_res)
	);

endmodule

// ===== rtl/rpa_front.sv =====
// ----------------------------------------------------------------------------
// Autotuner front end
// Takes request transfers into a short queue that the back end drains.
// ----------------------------------------------------------------------------
module rpa_front #(
	parameter int unsigned DEPTH = rpa_pkg::QUEUE_DEPTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [rpa_pkg::REQ_W-1:0]           req_type,
	input  logic signed [rpa_pkg::TEMP_W-1:0]   temp_centi,
	input  logic [rpa_pkg::TIME_W-1:0]          now_ms,
	output logic                                q_valid,
	output rpa_pkg::item_t                      q_item,
	input  logic                                q_pop
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	rpa_pkg::item_t    mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              push;
	logic              pop;

	assign in_stall = (cnt_q == CNT_FULL);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != '0);
	assign pop      = q_pop && q_valid;
	assign q_item   = mem_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= '{req: req_type, temp: temp_centi, now: now_ms};
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/rpa_alu.sv =====
// ----------------------------------------------------------------------------
// Autotuner serial arithmetic unit
// Shift-add multiply (32 steps) and restoring divide (64 steps), one bit
// per cycle, shared by all gain computations.
// ----------------------------------------------------------------------------
module rpa_alu (
	input  logic               clk,
	input  logic               arst_n,
	input  rpa_pkg::alu_req_t  req,
	output rpa_pkg::alu_rsp_t  rsp
);

	logic              busy_q;
	logic              done_q;
	rpa_pkg::alu_op_t  op_q;
	logic [6:0]        cnt_q;
	logic [79:0]       mcand_q;
	logic [31:0]       mplier_q;
	logic [79:0]       acc_q;
	logic [63:0]       rem_q;
	logic [63:0]       quo_q;
	logic [63:0]       den_q;
	logic [64:0]       trial;
	logic              last;

	assign trial = {rem_q, quo_q[63]};
	assign last  = (op_q == rpa_pkg::ALU_MUL) ? (cnt_q == 7'd31) : (cnt_q == 7'd63);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= rpa_pkg::ALU_MUL;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				op_q   <= req.op;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			mcand_q  <= {16'd0, req.opa};
			mplier_q <= req.opb[31:0];
			acc_q    <= '0;
			quo_q    <= req.opa;
			rem_q    <= '0;
			den_q    <= req.opb;
		end else if (busy_q) begin
			if (op_q == rpa_pkg::ALU_MUL) begin
				if (mplier_q[0]) begin
					acc_q <= acc_q + mcand_q;
				end
				mcand_q  <= {mcand_q[78:0], 1'b0};
				mplier_q <= {1'b0, mplier_q[31:1]};
			end else begin
				if (trial >= {1'b0, den_q}) begin
					rem_q <= 64'(trial - {1'b0, den_q});
					quo_q <= {quo_q[62:0], 1'b1};
				end else begin
					rem_q <= trial[63:0];
					quo_q <= {quo_q[62:0], 1'b0};
				end
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.ovf  = (op_q == rpa_pkg::ALU_MUL) && (acc_q[79:64] != '0);
	assign rsp.res  = (op_q == rpa_pkg::ALU_MUL) ? acc_q[63:0] : quo_q;

endmodule

// ===== rtl/rpa_back.sv =====
// ----------------------------------------------------------------------------
// Autotuner back end
// Executes queued requests: heater control, timeout, peak detection and the
// gain sequence on the serial unit. Holds the result register.
// ----------------------------------------------------------------------------
`include "relay_pid_autotuner_top_defines.svh"

module rpa_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_valid,
	input  rpa_pkg::item_t                    q_item,
	output logic                              q_pop,
	input  logic signed [rpa_pkg::TEMP_W-1:0] setpoint,
	input  logic [rpa_pkg::AMP_W-1:0]         relay_d,
	output rpa_pkg::alu_req_t                 alu_req,
	input  rpa_pkg::alu_rsp_t                 alu_rsp,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              heater_on,
	output logic [2:0]                        phase,
	output logic [rpa_pkg::PCT_W-1:0]         progress_pct,
	output logic [rpa_pkg::KP_W-1:0]          kp_milli,
	output logic [rpa_pkg::KI_W-1:0]          ki_milli,
	output logic [rpa_pkg::KD_W-1:0]          kd_milli,
	output logic                              done_res
);

	// architectural state
	rpa_pkg::back_state_t         state_q, state_n;
	rpa_pkg::phase_t              phase_q, phase_n;
	logic                         heater_q, heater_n;
	logic signed [17:0]           fpk_temp_q, fpk_temp_n;
	logic [31:0]                  fpk_time_q, fpk_time_n;
	logic [31:0]                  start_q, start_n;
	logic [31:0]                  safety_q, safety_n;
	logic signed [17:0]           prev_temp_q, prev_temp_n;
	logic                         rising_q, rising_n;
	logic signed [17:0]           prev_ch_q, prev_ch_n;
	logic [2:0]                   steady_q, steady_n;
	logic [rpa_pkg::PCT_W-1:0]    progress_q, progress_n;
	logic [rpa_pkg::KP_W-1:0]     kp_q, kp_n;
	logic [rpa_pkg::KI_W-1:0]     ki_q, ki_n;
	logic [rpa_pkg::KD_W-1:0]     kd_q, kd_n;

	// gain sequence operands
	logic [16:0]                  a2_q;
	logic [31:0]                  tper_q;
	logic [63:0]                  den_q;
	logic [63:0]                  num_q;
	logic [63:0]                  prod_q;
	logic                         issued_q;
	logic                         calc_go;

	// result register
	logic                         out_valid_q;
	logic                         out_heater_q;
	logic [2:0]                   out_phase_q;
	logic [rpa_pkg::PCT_W-1:0]    out_pct_q;
	logic [rpa_pkg::KP_W-1:0]     out_kp_q;
	logic [rpa_pkg::KI_W-1:0]     out_ki_q;
	logic [rpa_pkg::KD_W-1:0]     out_kd_q;

	logic                         slot_free;
	logic                         pop;
	logic                         load_pop;
	logic                         load_wr;
	logic                         calc_state;

	// item fields, widened
	logic signed [17:0]           t;
	logic signed [17:0]           sp;
	logic [31:0]                  now;
	logic [31:0]                  elapsed;
	logic [41:0]                  pct_prod;
	logic [rpa_pkg::PCT_W-1:0]    pct;
	logic signed [17:0]           a2;
	logic [31:0]                  tper;

	// peak detector results
	logic signed [17:0]           ch;
	logic                         pk_hit;
	logic                         pk_rising;
	logic signed [17:0]           pk_ch;
	logic [2:0]                   pk_steady;
	logic [2:0]                   sc_inc;

	assign t   = 18'(q_item.temp);
	assign sp  = 18'(setpoint);
	assign now = q_item.now;

	assign slot_free = !out_valid_q || !out_stall;
	assign pop       = (state_q == rpa_pkg::BS_IDLE) && q_valid && slot_free;
	assign q_pop     = pop;
	assign load_pop  = pop && !calc_go;
	assign load_wr   = (state_q == rpa_pkg::BS_WRITE) && slot_free;

	// progress from elapsed time by reciprocal multiply
	assign elapsed  = now - start_q;
	assign pct_prod = 42'(elapsed[20:0]) * 42'(rpa_pkg::PCT_RECIP);
	assign pct      = pct_prod[41:35];

	assign a2   = fpk_temp_q + t - (sp <<< 1);
	assign tper = now - fpk_time_q;

	// direction and steady-count peak detector
	always_comb begin
		ch        = t - prev_temp_q;
		pk_hit    = 1'b0;
		pk_rising = rising_q;
		pk_ch     = ch;
		pk_steady = steady_q;
		sc_inc    = (steady_q < 3'd7) ? steady_q + 3'd1 : steady_q;
		if (rising_q && ch < -18'sd5) begin
			pk_rising = 1'b0;
			pk_steady = '0;
			if (prev_ch_q > 18'sd0) begin
				pk_hit = 1'b1;
				pk_ch  = prev_ch_q;
			end
		end else if (!rising_q && ch > 18'sd5) begin
			pk_rising = 1'b1;
			pk_steady = '0;
		end else if (ch > -18'sd3 && ch < 18'sd3) begin
			pk_steady = sc_inc;
			if (sc_inc > 3'd5) begin
				if (rising_q && prev_ch_q < 18'sd0) begin
					pk_rising = 1'b0;
					pk_steady = '0;
					pk_hit    = 1'b1;
					pk_ch     = prev_ch_q;
				end else if (!rising_q && prev_ch_q > 18'sd0) begin
					pk_rising = 1'b1;
					pk_steady = '0;
				end
			end
		end else begin
			pk_steady = '0;
		end
	end

	// request execution
	always_comb begin
		phase_n     = phase_q;
		heater_n    = heater_q;
		fpk_temp_n  = fpk_temp_q;
		fpk_time_n  = fpk_time_q;
		start_n     = start_q;
		safety_n    = safety_q;
		prev_temp_n = prev_temp_q;
		rising_n    = rising_q;
		prev_ch_n   = prev_ch_q;
		steady_n    = steady_q;
		progress_n  = progress_q;
		kp_n        = kp_q;
		ki_n        = ki_q;
		kd_n        = kd_q;
		calc_go     = 1'b0;
		unique case (q_item.req)
			rpa_pkg::REQ_START: begin
				phase_n     = rpa_pkg::PH_INIT;
				start_n     = now;
				safety_n    = now;
				prev_temp_n = t;
				progress_n  = '0;
				heater_n    = 1'b1;
			end
			rpa_pkg::REQ_CANCEL: begin
				phase_n    = rpa_pkg::PH_CANCELED;
				progress_n = '0;
			end
			rpa_pkg::REQ_SAMPLE: begin
				if (phase_q != rpa_pkg::PH_CANCELED && phase_q != rpa_pkg::PH_FINISHED) begin
					// periodic safety check
					if ((now - safety_q) > rpa_pkg::SAFETY_MS) begin
						safety_n = now;
						if (t >= sp + 18'sd200) heater_n = 1'b0;
						if (t <= sp - 18'sd500) heater_n = 1'b1;
					end
					if (elapsed > rpa_pkg::TIMEOUT_MS) begin
						phase_n    = rpa_pkg::PH_CANCELED;
						progress_n = '0;
					end else begin
						progress_n  = (pct > rpa_pkg::PCT_CAP) ? rpa_pkg::PCT_CAP : pct;
						prev_temp_n = t;
						if (phase_q == rpa_pkg::PH_INIT) begin
							if (t >= sp + 18'sd50) begin
								heater_n = 1'b0;
								phase_n  = rpa_pkg::PH_PEAK1;
							end
						end else begin
							rising_n  = pk_rising;
							prev_ch_n = pk_ch;
							steady_n  = pk_steady;
							if (pk_hit) begin
								if (phase_q == rpa_pkg::PH_PEAK1) begin
									fpk_temp_n = t;
									fpk_time_n = now;
									phase_n    = rpa_pkg::PH_PEAK2;
								end else begin
									phase_n    = rpa_pkg::PH_FINISHED;
									progress_n = rpa_pkg::PCT_DONE;
									// degenerate amplitudes settle at once
									if (relay_d == '0 || a2 < 18'sd0) begin
										kp_n = rpa_pkg::KP_W'(rpa_pkg::KP_MIN);
										ki_n = rpa_pkg::KI_W'(rpa_pkg::KI_MIN);
										kd_n = rpa_pkg::KD_W'(rpa_pkg::KD_MIN);
									end else if (a2 == 18'sd0) begin
										kp_n = rpa_pkg::KP_W'(rpa_pkg::KP_MAX);
										ki_n = rpa_pkg::KI_W'(rpa_pkg::KI_MAX);
										kd_n = (tper != '0) ? rpa_pkg::KD_W'(rpa_pkg::KD_MAX)
										                    : rpa_pkg::KD_W'(rpa_pkg::KD_MIN);
									end else begin
										calc_go = 1'b1;
									end
								end
							end
							// hysteresis around the setpoint
							if (t <= sp - 18'sd50) heater_n = 1'b1;
							else if (t >= sp + 18'sd50) heater_n = 1'b0;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	// sequencer next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			rpa_pkg::BS_IDLE:  if (pop && calc_go) state_n = rpa_pkg::BS_DEN;
			rpa_pkg::BS_DEN:   if (alu_rsp.done) state_n = rpa_pkg::BS_NKP;
			rpa_pkg::BS_NKP:   if (alu_rsp.done) state_n = rpa_pkg::BS_KP;
			rpa_pkg::BS_KP: begin
				if (alu_rsp.done) begin
					state_n = (tper_q == '0) ? rpa_pkg::BS_N1 : rpa_pkg::BS_NKI;
				end
			end
			rpa_pkg::BS_NKI:   if (alu_rsp.done) state_n = rpa_pkg::BS_DT;
			rpa_pkg::BS_DT: begin
				if (alu_rsp.done) begin
					state_n = alu_rsp.ovf ? rpa_pkg::BS_N1 : rpa_pkg::BS_KI;
				end
			end
			rpa_pkg::BS_KI:    if (alu_rsp.done) state_n = rpa_pkg::BS_N1;
			rpa_pkg::BS_N1:    if (alu_rsp.done) state_n = rpa_pkg::BS_NT;
			rpa_pkg::BS_NT: begin
				if (alu_rsp.done) begin
					state_n = alu_rsp.ovf ? rpa_pkg::BS_WRITE : rpa_pkg::BS_KD;
				end
			end
			rpa_pkg::BS_KD:    if (alu_rsp.done) state_n = rpa_pkg::BS_WRITE;
			rpa_pkg::BS_WRITE: if (slot_free) state_n = rpa_pkg::BS_IDLE;
			default:           state_n = rpa_pkg::BS_IDLE;
		endcase
	end

	// sequencer outputs: operands for the serial unit
	always_comb begin
		calc_state  = 1'b1;
		alu_req.op  = rpa_pkg::ALU_MUL;
		alu_req.opa = '0;
		alu_req.opb = '0;
		unique case (state_q)
			rpa_pkg::BS_DEN: begin
				alu_req.opa = rpa_pkg::K_PI;
				alu_req.opb = 64'(a2_q);
			end
			rpa_pkg::BS_NKP: begin
				alu_req.opa = rpa_pkg::K_KP_NUM;
				alu_req.opb = 64'(relay_d);
			end
			rpa_pkg::BS_KP: begin
				alu_req.op  = rpa_pkg::ALU_DIV;
				alu_req.opa = num_q;
				alu_req.opb = den_q;
			end
			rpa_pkg::BS_NKI: begin
				alu_req.opa = rpa_pkg::K_KI_NUM;
				alu_req.opb = 64'(relay_d);
			end
			rpa_pkg::BS_DT: begin
				alu_req.opa = den_q;
				alu_req.opb = 64'(tper_q);
			end
			rpa_pkg::BS_KI: begin
				alu_req.op  = rpa_pkg::ALU_DIV;
				alu_req.opa = num_q;
				alu_req.opb = prod_q;
			end
			rpa_pkg::BS_N1: begin
				alu_req.opa = rpa_pkg::K_KD_NUM;
				alu_req.opb = 64'(relay_d);
			end
			rpa_pkg::BS_NT: begin
				alu_req.opa = prod_q;
				alu_req.opb = 64'(tper_q);
			end
			rpa_pkg::BS_KD: begin
				alu_req.op  = rpa_pkg::ALU_DIV;
				alu_req.opa = num_q;
				alu_req.opb = den_q;
			end
			default: calc_state = 1'b0;
		endcase
		alu_req.start = calc_state && !issued_q;
	end

	// control and architectural registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rpa_pkg::BS_IDLE;
			phase_q     <= rpa_pkg::PH_CANCELED;
			heater_q    <= 1'b0;
			fpk_temp_q  <= '0;
			fpk_time_q  <= '0;
			start_q     <= '0;
			safety_q    <= '0;
			prev_temp_q <= '0;
			rising_q    <= 1'b1;
			prev_ch_q   <= '0;
			steady_q    <= '0;
			progress_q  <= '0;
			kp_q        <= '0;
			ki_q        <= '0;
			kd_q        <= '0;
			issued_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (alu_rsp.done) begin
				issued_q <= 1'b0;
			end else if (alu_req.start) begin
				issued_q <= 1'b1;
			end
			if (pop) begin
				phase_q     <= phase_n;
				heater_q    <= heater_n;
				fpk_temp_q  <= fpk_temp_n;
				fpk_time_q  <= fpk_time_n;
				start_q     <= start_n;
				safety_q    <= safety_n;
				prev_temp_q <= prev_temp_n;
				rising_q    <= rising_n;
				prev_ch_q   <= prev_ch_n;
				steady_q    <= steady_n;
				progress_q  <= progress_n;
				kp_q        <= kp_n;
				ki_q        <= ki_n;
				kd_q        <= kd_n;
			end else if (alu_rsp.done) begin
				// clamp each quotient as it lands
				unique case (state_q)
					rpa_pkg::BS_KP: begin
						kp_q <= (alu_rsp.res < rpa_pkg::KP_MIN) ? rpa_pkg::KP_W'(rpa_pkg::KP_MIN) :
						        (alu_rsp.res > rpa_pkg::KP_MAX) ? rpa_pkg::KP_W'(rpa_pkg::KP_MAX) :
						        alu_rsp.res[rpa_pkg::KP_W-1:0];
						if (tper_q == '0) ki_q <= rpa_pkg::KI_W'(rpa_pkg::KI_MAX);
					end
					rpa_pkg::BS_DT: begin
						if (alu_rsp.ovf) ki_q <= rpa_pkg::KI_W'(rpa_pkg::KI_MIN);
					end
					rpa_pkg::BS_KI: begin
						ki_q <= (alu_rsp.res < rpa_pkg::KI_MIN) ? rpa_pkg::KI_W'(rpa_pkg::KI_MIN) :
						        (alu_rsp.res > rpa_pkg::KI_MAX) ? rpa_pkg::KI_W'(rpa_pkg::KI_MAX) :
						        alu_rsp.res[rpa_pkg::KI_W-1:0];
					end
					rpa_pkg::BS_NT: begin
						if (alu_rsp.ovf) kd_q <= rpa_pkg::KD_W'(rpa_pkg::KD_MAX);
					end
					rpa_pkg::BS_KD: begin
						kd_q <= (alu_rsp.res < rpa_pkg::KD_MIN) ? rpa_pkg::KD_W'(rpa_pkg::KD_MIN) :
						        (alu_rsp.res > rpa_pkg::KD_MAX) ? rpa_pkg::KD_W'(rpa_pkg::KD_MAX) :
						        alu_rsp.res[rpa_pkg::KD_W-1:0];
					end
					default: begin
					end
				endcase
			end
			if (load_pop || load_wr) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// gain sequence operand registers
	always_ff @(posedge clk) begin
		if (pop && calc_go) begin
			a2_q   <= a2[16:0];
			tper_q <= tper;
		end
		if (alu_rsp.done) begin
			unique case (state_q)
				rpa_pkg::BS_DEN: den_q  <= alu_rsp.res;
				rpa_pkg::BS_NKP: num_q  <= alu_rsp.res;
				rpa_pkg::BS_NKI: num_q  <= alu_rsp.res;
				rpa_pkg::BS_DT:  prod_q <= alu_rsp.res;
				rpa_pkg::BS_N1:  prod_q <= alu_rsp.res;
				rpa_pkg::BS_NT:  num_q  <= alu_rsp.res;
				default: begin
				end
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (load_pop) begin
			out_heater_q <= heater_n;
			out_phase_q  <= phase_n;
			out_pct_q    <= progress_n;
			out_kp_q     <= kp_n;
			out_ki_q     <= ki_n;
			out_kd_q     <= kd_n;
		end else if (load_wr) begin
			out_heater_q <= heater_q;
			out_phase_q  <= phase_q;
			out_pct_q    <= progress_q;
			out_kp_q     <= kp_q;
			out_ki_q     <= ki_q;
			out_kd_q     <= kd_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign heater_on    = out_heater_q;
	assign phase        = out_phase_q;
	assign progress_pct = out_pct_q;
	assign kp_milli     = out_kp_q;
	assign ki_milli     = out_ki_q;
	assign kd_milli     = out_kd_q;
	assign done_res     = (out_phase_q == rpa_pkg::PH_FINISHED);

	// a new operation is never issued on top of a running one
	`RPA_ASSERT(a_alu_idle_start, alu_req.start |-> !alu_rsp.busy)
	// a request is only taken when the result register can receive it
	`RPA_ASSERT(a_pop_slot, q_pop |-> (!out_valid_q || !out_stall))
	// the gain sequence only runs after the second peak
	`RPA_ASSERT(a_calc_finished, calc_state |-> (phase_q == rpa_pkg::PH_FINISHED))
	// progress never exceeds one hundred percent
	`RPA_ASSERT_ALWAYS(a_progress_range, progress_q <= rpa_pkg::PCT_DONE)

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Relay PID autotuner testbench
// Drives a directed table and then random tuning episodes through the
// request channel, with random gaps and result stalls, and compares every
// result with a bit-exact predictor of the tuner. Setpoint and relay
// amplitude are rewritten between some episodes while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
	import rpa_pkg::*;

	localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;
	localparam int unsigned      ITEM_GOAL   = 1500;
	localparam int unsigned      CYCLE_LIMIT = 3000000;
	localparam int unsigned      GAIN_SETTLE = 600;

	typedef struct packed {
		logic              heat;
		phase_t            ph;
		logic [PCT_W-1:0]  pct;
		logic [KP_W-1:0]   kp;
		logic [KI_W-1:0]   ki;
		logic [KD_W-1:0]   kd;
		logic              done;
	} tune_out_t;

	typedef struct {
		logic [REQ_W-1:0]         rq;
		logic signed [TEMP_W-1:0] tp;
		logic [TIME_W-1:0]        nw;
		bit                       typed;
		logic                     w_heat;
		phase_t                   w_ph;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [REQ_W-1:0] req_type = '0;
	logic signed [TEMP_W-1:0] temp_centi = '0;
	logic [TIME_W-1:0] now_ms = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic heater_on;
	logic [2:0] phase;
	logic [PCT_W-1:0] progress_pct;
	logic [KP_W-1:0] kp_milli;
	logic [KI_W-1:0] ki_milli;
	logic [KD_W-1:0] kd_milli;
	logic done_res;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data = '0;

	relay_pid_autotuner_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .temp_centi(temp_centi), .now_ms(now_ms),
		.out_valid(out_valid), .out_stall(out_stall),
		.heater_on(heater_on), .phase(phase), .progress_pct(progress_pct),
		.kp_milli(kp_milli), .ki_milli(ki_milli), .kd_milli(kd_milli),
		.done_res(done_res),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// tuner shadow state
	logic [TEMP_W-1:0] sp_cfg = SETPOINT_RST;
	logic [AMP_W-1:0]  d_cfg  = RELAY_D_RST;
	phase_t      m_ph = PH_CANCELED;
	logic        m_heat = 1'b0;
	int          m_pk_temp = 0;
	logic [31:0] m_pk_time = '0;
	logic [31:0] m_t_start = '0;
	logic [31:0] m_t_safe = '0;
	int          m_prev_temp = 0;
	bit          m_rising = 1'b1;
	int          m_prev_ch = 0;
	int          m_steady = 0;
	int          m_pct = 0;
	logic [31:0] m_gain [3] = '{32'd0, 32'd0, 32'd0};

	tune_out_t pending_results [$];
	int unsigned errors = 0;
	int unsigned items_sent = 0;
	int unsigned cycles = 0;
	int unsigned stall_left = 0;
	bit sink_busy_free = 1'b0;
	bit src_gap_free = 1'b0;

	// peak detector: direction flag plus steady counter
	function automatic bit peak_found(input int t);
		int ch;
		ch = t - m_prev_temp;
		if (m_rising && ch < -5) begin
			m_rising = 1'b0;
			m_steady = 0;
			if (m_prev_ch > 0) return 1'b1;
		end else if (!m_rising && ch > 5) begin
			m_rising = 1'b1;
			m_steady = 0;
		end else if (ch > -3 && ch < 3) begin
			if (m_steady < 7) m_steady++;
			if (m_steady > 5) begin
				if (m_rising && m_prev_ch < 0) begin
					m_rising = 1'b0;
					m_steady = 0;
					return 1'b1;
				end else if (!m_rising && m_prev_ch > 0) begin
					m_rising = 1'b1;
					m_steady = 0;
				end
			end
		end else begin
			m_steady = 0;
		end
		m_prev_ch = ch;
		return 1'b0;
	endfunction

	function automatic longint unsigned clip(input longint unsigned v,
			input longint unsigned lo, input longint unsigned hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	// Ziegler-Nichols gains from the doubled amplitude and the period
	function automatic void zn_gains(input int a2, input logic [31:0] per);
		longint unsigned kp, ki, kd, den, n1, dd, tt, top;
		dd = d_cfg;
		tt = per;
		top = 64'hFFFF_FFFF_FFFF_FFFF;
		if (dd == 0 || a2 < 0) begin
			kp = KP_MIN; ki = KI_MIN; kd = KD_MIN;
		end else if (a2 == 0) begin
			kp = KP_MAX; ki = KI_MAX;
			kd = (tt > 0) ? KD_MAX : KD_MIN;
		end else begin
			den = K_PI * longint'(a2);
			kp = (K_KP_NUM * dd) / den;
			if (tt == 0) ki = KI_MAX;
			else if (tt > top / den) ki = 0;
			else ki = (K_KI_NUM * dd) / (den * tt);
			n1 = K_KD_NUM * dd;
			if (tt > top / n1) kd = KD_MAX;
			else kd = (n1 * tt) / den;
			kp = clip(kp, KP_MIN, KP_MAX);
			ki = clip(ki, KI_MIN, KI_MAX);
			kd = clip(kd, KD_MIN, KD_MAX);
		end
		m_gain[0] = kp[31:0];
		m_gain[1] = ki[31:0];
		m_gain[2] = kd[31:0];
	endfunction

	function automatic void relay_band(input int t, input int sp);
		if (t <= sp - 50) m_heat = 1'b1;
		else if (t >= sp + 50) m_heat = 1'b0;
	endfunction

	function automatic void take_sample(input int t, input logic [31:0] nw);
		int sp;
		logic [31:0] el;
		logic [31:0] q;
		sp = $signed(sp_cfg);
		if (m_ph == PH_CANCELED || m_ph == PH_FINISHED) return;
		// safety check every 5 s
		if (nw - m_t_safe > SAFETY_MS) begin
			m_t_safe = nw;
			if (t >= sp + 200) m_heat = 1'b0;
			if (t <= sp - 500) m_heat = 1'b1;
		end
		el = nw - m_t_start;
		if (el > TIMEOUT_MS) begin
			m_ph = PH_CANCELED;
			m_pct = 0;
			return;
		end
		q = el / 32'd18000;
		m_pct = (q > 95) ? 95 : int'(q);
		case (m_ph)
			PH_INIT: begin
				if (t >= sp + 50) begin
					m_heat = 1'b0;
					m_ph = PH_PEAK1;
				end
			end
			PH_PEAK1: begin
				if (peak_found(t)) begin
					m_pk_temp = t;
					m_pk_time = nw;
					m_ph = PH_PEAK2;
				end
				relay_band(t, sp);
			end
			PH_PEAK2: begin
				if (peak_found(t)) begin
					zn_gains(m_pk_temp + t - 2 * sp, nw - m_pk_time);
					m_ph = PH_FINISHED;
					m_pct = 100;
				end
				relay_band(t, sp);
			end
			default: ;
		endcase
		m_prev_temp = t;
	endfunction

	// one request through the tuner shadow, returns the expected result
	function automatic tune_out_t tune_step(input logic [REQ_W-1:0] rq,
			input logic signed [TEMP_W-1:0] tp, input logic [TIME_W-1:0] nw);
		tune_out_t r;
		int t;
		t = tp;
		if (rq == REQ_START) begin
			m_ph = PH_INIT;
			m_t_start = nw;
			m_t_safe = nw;
			m_prev_temp = t;
			m_pct = 0;
			m_heat = 1'b1;
		end else if (rq == REQ_CANCEL) begin
			m_ph = PH_CANCELED;
			m_pct = 0;
		end else if (rq == REQ_SAMPLE) begin
			take_sample(t, nw);
		end
		r.heat = m_heat;
		r.ph   = m_ph;
		r.pct  = m_pct[PCT_W-1:0];
		r.kp   = m_gain[0][KP_W-1:0];
		r.ki   = m_gain[1][KI_W-1:0];
		r.kd   = m_gain[2][KD_W-1:0];
		r.done = (m_ph == PH_FINISHED);
		return r;
	endfunction

	task automatic field_check(input string fname, input longint e, input longint a);
		if (e != a) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, e, a);
		end
	endtask

	// result side: compare each transfer with the oldest expectation
	always @(posedge clk) begin
		tune_out_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: result with nothing expected, actual phase %0d",
					$time, phase);
			end else begin
				w = pending_results.pop_front();
				field_check("heater_on", w.heat, heater_on);
				field_check("phase", w.ph, phase);
				field_check("progress_pct", w.pct, progress_pct);
				field_check("kp_milli", w.kp, kp_milli);
				field_check("ki_milli", w.ki, ki_milli);
				field_check("kd_milli", w.kd, kd_milli);
				field_check("done_res", w.done, done_res);
			end
			stall_left = sink_busy_free ? 0 : $urandom_range(0, 8);
		end
	end

	// receiver stall pattern, with stall-free stretches
	always @(negedge clk) begin
		if ($urandom_range(0, 299) == 0) sink_busy_free = ~sink_busy_free;
		if ($urandom_range(0, 299) == 0) src_gap_free = ~src_gap_free;
		if (arst_n && stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// one request transfer; entered and left at a falling edge
	task automatic send_req(input logic [REQ_W-1:0] rq, input logic signed [TEMP_W-1:0] tp,
			input logic [TIME_W-1:0] nw, input bit typed, input tune_out_t want);
		int unsigned gap;
		tune_out_t p;
		gap = src_gap_free ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid   <= 1'b1;
		req_type   <= rq;
		temp_centi <= tp;
		now_ms     <= nw;
		forever begin
			@(posedge clk);
			if (!in_stall) break;
		end
		p = tune_step(rq, tp, nw);
		pending_results.push_back(typed ? want : p);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_plain(input logic [REQ_W-1:0] rq, input int tp, input logic [31:0] nw);
		int c;
		c = (tp > 15000) ? 15000 : ((tp < -4000) ? -4000 : tp);
		send_req(rq, c[TEMP_W-1:0], nw, 1'b0, '0);
	endtask

	// register write, only while nothing is in flight
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (GAIN_SETTLE) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		forever begin
			@(posedge clk);
			if (cfg_ready) break;
		end
		if (idx == CFG_SETPOINT) sp_cfg = val;
		else d_cfg = val[AMP_W-1:0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	dir_row_t dir_tab [20] = '{
		'{REQ_SAMPLE,  15'sd0,     32'd0,          1'b1, 1'b0, PH_CANCELED},
		'{REQ_UNKNOWN, 15'sh3FFF,  32'hFFFF_FFFF,  1'b1, 1'b0, PH_CANCELED},
		'{REQ_CANCEL,  15'sh4000,  32'd0,          1'b1, 1'b0, PH_CANCELED},
		'{REQ_START,   15'sd3000,  32'd1000,       1'b1, 1'b1, PH_INIT},
		'{REQ_SAMPLE,  15'sd3850,  32'd2000,       1'b0, 1'b0, PH_CANCELED},
		'{REQ_SAMPLE,  15'sd3900,  32'd3000,       1'b0, 1'b0, PH_CANCELED},
		'{REQ_SAMPLE,  15'sd3950,  32'd4000,       1'b0, 1'b0, PH_CANCELED},
		'{REQ_SAMPLE,  15'sd4000,  32'd5000,       1'b0, 1'b0, PH_CANCELED},
		'{REQ_SAMPLE,  15'sd3980,  32'd6000,       1'b0, 1'b0, PH_CANCELED},
		'{REQ_SAMPLE,  15'sd3900,  32'd7000,       1'b0, 1'b0, PH_CANCELED},
		'{REQ_SAMPLE,  15'sd3800,  32'd8000,       1'b0, 1'b0, PH_CANCELED},
		'{REQ_SAMPLE,  15'sd3700,  32'd9000,       1'b0, 1'b0, PH_CANCELED},
		'{REQ_SAMPLE,  15'sd3750,  32'd10000,      1'b0, 1'b0, PH_CANCELED},
		'{REQ_SAMPLE,  15'sd3800,  32'd11000,      1'b0, 1'b0, PH_CANCELED},
		'{REQ_SAMPLE,  15'sd3790,  32'd12000,      1'b0, 1'b0, PH_CANCELED},
		'{REQ_SAMPLE,  15'sd3000,  32'd13000,      1'b0, 1'b0, PH_CANCELED},
		'{REQ_START,   15'sd15000, 32'hFFFF_F000,  1'b0, 1'b0, PH_CANCELED},
		'{REQ_SAMPLE,  -15'sd4000, 32'h0000_1000,  1'b0, 1'b0, PH_CANCELED},
		'{REQ_SAMPLE,  15'sd5000,  32'h001B_8000,  1'b0, 1'b0, PH_CANCELED},
		'{REQ_CANCEL,  15'sd0,     32'd0,          1'b0, 1'b0, PH_CANCELED}
	};

	initial begin
		tune_out_t want;
		logic [31:0] now;
		int sp, ctr, amp, tmp, dir, flat, n, pick, hi, lo;
		int unsigned episode;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table
		foreach (dir_tab[i]) begin
			want = '0;
			want.heat = dir_tab[i].w_heat;
			want.ph   = dir_tab[i].w_ph;
			send_req(dir_tab[i].rq, dir_tab[i].tp, dir_tab[i].nw, dir_tab[i].typed, want);
		end

		// random tuning episodes, registers changed between some of them
		now = 32'd50000;
		episode = 0;
		while (items_sent < ITEM_GOAL) begin
			case (episode)
				0: begin write_reg(CFG_SETPOINT, -15'sd4000); write_reg(CFG_RELAY_D, 15'd1); end
				3: begin write_reg(CFG_SETPOINT, 15'sd15000); write_reg(CFG_RELAY_D, 15'd1000); end
				6: begin write_reg(CFG_SETPOINT, 15'sd0); write_reg(CFG_RELAY_D, 15'h7C00); end
				9: begin write_reg(CFG_SETPOINT, SETPOINT_RST); write_reg(CFG_RELAY_D, 15'd1023); end
				default: begin
					if ($urandom_range(0, 3) == 0) begin
						write_reg(CFG_SETPOINT, $urandom_range(0, 19000) - 4000);
						write_reg(CFG_RELAY_D, $urandom_range(0, 32767));
					end
				end
			endcase
			episode++;
			sp  = $signed(sp_cfg);
			ctr = sp + $urandom_range(0, 400) - 150;
			amp = $urandom_range(20, 800);
			tmp = sp - $urandom_range(0, 1500);
			now += $urandom_range(0, 5000);
			if ($urandom_range(0, 7) == 0) now = 32'hFFFF_FFFF - $urandom_range(0, 200000);
			send_plain(REQ_START, tmp, now);
			n = $urandom_range(30, 120);
			dir = 1;
			flat = 0;
			hi = (ctr + amp > sp + 60) ? ctr + amp : sp + 60;
			for (int i = 0; i < n; i++) begin
				pick = $urandom_range(0, 99);
				if (pick < 3) begin
					now += $urandom_range(0, 3000);
					send_req($urandom_range(0, 3), $urandom_range(0, 32767), now, 1'b0, '0);
				end else if (pick < 5) begin
					send_plain(REQ_CANCEL, tmp, now);
				end else if (pick == 5) begin
					now += 32'd1800001 + $urandom_range(0, 1000);
					send_plain(REQ_SAMPLE, tmp, now);
				end else begin
					if (flat > 0) begin
						flat--;
						tmp += $urandom_range(0, 4) - 2;
					end else begin
						if ($urandom_range(0, 19) == 0) flat = $urandom_range(5, 8);
						tmp += dir * $urandom_range(5, 80);
						lo = ctr - amp;
						if (tmp >= hi) begin
							dir = -1;
							hi = ctr + amp;
						end
						if (tmp <= lo) dir = 1;
					end
					now += ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(100, 3000);
					send_plain(REQ_SAMPLE, tmp, now);
				end
			end
		end

		// drain
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (GAIN_SETTLE) @(negedge clk);
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
